[rtl/core/ple_pkg.sv]
// shared types, codes and sizes for the positional list engine
package ple_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int LIDX_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    localparam int OP_W        = 3;
    localparam int POS_W       = 5;
    localparam int VAL_W       = 32;
    localparam int ST_W        = 2;
    localparam int ECNT_W      = 5;

    // width for comparing slots, positions and counts
    localparam int CMP_W       = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // request codes
    localparam logic [OP_W-1:0] OP_APPEND     = 3'd0;
    localparam logic [OP_W-1:0] OP_PREPEND    = 3'd1;
    localparam logic [OP_W-1:0] OP_REM_LAST   = 3'd2;
    localparam logic [OP_W-1:0] OP_REM_FIRST  = 3'd3;
    localparam logic [OP_W-1:0] OP_INSERT_AT  = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE_AT  = 3'd5;
    localparam logic [OP_W-1:0] OP_LIST_ALL   = 3'd6;

    // status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

    // per-cell commands
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CELL_HOLD  = 3'd0;
    localparam logic [CMD_W-1:0] CELL_LOAD  = 3'd1;
    localparam logic [CMD_W-1:0] CELL_LEFT  = 3'd2;
    localparam logic [CMD_W-1:0] CELL_RIGHT = 3'd3;
    localparam logic [CMD_W-1:0] CELL_WRAP  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_in_beat;

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic [ST_W-1:0]         status;
        logic [ECNT_W-1:0]       entry_count;
        logic                    last_item;
    } t_out_beat;

    typedef struct packed {
        logic [MAX_ENTRIES-1:0][CMD_W-1:0] cmd;
        logic signed [VAL_W-1:0]           value;
    } t_chain_ctl;

endpackage

[rtl/core/positional_list_engine.sv]
// top level of the positional list engine: controller plus chain of cells
// an update result is in the output register in the cycle after its beat is taken, a listing
// goes through the list state first; a new beat is taken while the output beat drains
// list-all: a decode step, then one chain rotation per entry; a single empty result if empty
// the next request is taken once the last listing beat is in the output register
// reset (i_rst_n low, synchronous) empties the list and drops any pending output beat
module positional_list_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ple_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ple_pkg::t_out_beat o_out_data
);
    import ple_pkg::*;

    // cell outputs; cell 0 is the front of the list
    logic signed [VAL_W-1:0] w_data [MAX_ENTRIES];
    t_chain_ctl              w_ctl;

    // controller: decodes requests, owns the count, steps the chain
    ple_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_head      (w_data[0]),
        .o_ctl       (w_ctl)
    );

    // chain: insert shifts cells back (take left), remove shifts forward (take right),
    // listing rotates the occupied part with the tail taking the head
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_data[g+1];
        end

        ple_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (w_ctl.cmd[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_data[0]),
            .i_value (w_ctl.value),
            .o_data  (w_data[g])
        );
    end

endmodule

[rtl/core/ple_cell.sv]
// one storage cell of the list chain
module ple_cell (
    input  logic                             i_clk,
    input  logic [ple_pkg::CMD_W-1:0]        i_cmd,
    input  logic signed [ple_pkg::VAL_W-1:0] i_left,
    input  logic signed [ple_pkg::VAL_W-1:0] i_right,
    input  logic signed [ple_pkg::VAL_W-1:0] i_head,
    input  logic signed [ple_pkg::VAL_W-1:0] i_value,
    output logic signed [ple_pkg::VAL_W-1:0] o_data
);
    import ple_pkg::*;

    logic signed [VAL_W-1:0] r_data;
    logic signed [VAL_W-1:0] n_data;

    always_comb begin
        case (i_cmd)
            CELL_LOAD:  n_data = i_value;
            CELL_LEFT:  n_data = i_left;
            CELL_RIGHT: n_data = i_right;
            CELL_WRAP:  n_data = i_head;
            default:    n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

[rtl/core/ple_ctrl.sv]
// request decode, count, listing sequencer and output register
module ple_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ple_pkg::t_in_beat                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ple_pkg::t_out_beat               o_out_data,
    input  logic signed [ple_pkg::VAL_W-1:0] i_head,
    output ple_pkg::t_chain_ctl              o_ctl
);
    import ple_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LIST = 1'b1;

    logic              r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [LIDX_W-1:0] r_list_idx, n_list_idx;
    logic              r_out_valid, n_out_valid;
    t_out_beat         r_out, n_out;

    logic             w_accept;
    logic             w_out_free;
    logic             w_full;
    logic             w_empty;
    logic [CMP_W-1:0] w_cnt_x;
    logic [CMP_W-1:0] w_pos_x;
    logic [CMP_W-1:0] w_slot;
    logic             w_do_ins;
    logic             w_do_rem;
    logic [ST_W-1:0]  w_st;
    logic             w_list_last;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_full     = (r_count == CNT_W'(MAX_ENTRIES));
    assign w_empty    = (r_count == '0);
    assign w_cnt_x    = CMP_W'(r_count);
    assign w_pos_x    = CMP_W'(i_in_data.position);
    assign w_list_last = (CMP_W'(r_list_idx) + CMP_W'(1)) == w_cnt_x;

    // request decode
    always_comb begin
        w_slot   = '0;
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        w_st     = ST_OK;
        case (i_in_data.operation)
            OP_APPEND: begin
                if (w_full) w_st = ST_FULL;
                else begin
                    w_do_ins = 1'b1;
                    w_slot   = w_cnt_x;
                end
            end
            OP_PREPEND: begin
                if (w_full) w_st = ST_FULL;
                else w_do_ins = 1'b1;
            end
            OP_REM_LAST: begin
                // dropping the tail shifts only the cells from the tail slot on; the count moves down
                if (w_empty) w_st = ST_EMPTY;
                else begin
                    w_do_rem = 1'b1;
                    w_slot   = w_cnt_x - CMP_W'(1);
                end
            end
            OP_REM_FIRST: begin
                if (w_empty) w_st = ST_EMPTY;
                else w_do_rem = 1'b1;
            end
            OP_INSERT_AT: begin
                if (w_empty) w_do_ins = 1'b1;
                else if (w_full) w_st = ST_FULL;
                else if (w_pos_x == '0) w_st = ST_RANGE;
                else if (w_pos_x - CMP_W'(1) > w_cnt_x) w_st = ST_RANGE;
                else begin
                    w_do_ins = 1'b1;
                    w_slot   = w_pos_x - CMP_W'(1);
                end
            end
            OP_REMOVE_AT: begin
                if (w_empty) w_st = ST_EMPTY;
                else if (w_pos_x == '0) w_st = ST_RANGE;
                else if (w_pos_x - CMP_W'(1) >= w_cnt_x) w_st = ST_RANGE;
                else begin
                    w_do_rem = 1'b1;
                    w_slot   = w_pos_x - CMP_W'(1);
                end
            end
            OP_LIST_ALL: begin
                if (w_empty) w_st = ST_EMPTY;
            end
            default: w_st = ST_OK;
        endcase
    end

    // sequencer and per-cell commands
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_list_idx  = r_list_idx;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        o_ctl.value = i_in_data.value;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            o_ctl.cmd[i] = CELL_HOLD;
        end

        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.operation == OP_LIST_ALL && !w_empty) begin
                        n_state    = S_LIST;
                        n_list_idx = '0;
                    end else begin
                        if (w_do_ins) begin
                            n_count = r_count + CNT_W'(1);
                            for (int i = 0; i < MAX_ENTRIES; i++) begin
                                if (CMP_W'(i) == w_slot) o_ctl.cmd[i] = CELL_LOAD;
                                else if (CMP_W'(i) > w_slot) o_ctl.cmd[i] = CELL_LEFT;
                            end
                        end
                        if (w_do_rem) begin
                            n_count = r_count - CNT_W'(1);
                            for (int i = 0; i < MAX_ENTRIES; i++) begin
                                if (CMP_W'(i) >= w_slot) o_ctl.cmd[i] = CELL_RIGHT;
                            end
                        end
                        n_out_valid       = 1'b1;
                        n_out.item_value  = '0;
                        n_out.status      = w_st;
                        n_out.entry_count = ECNT_W'(n_count);
                        n_out.last_item   = 1'b1;
                    end
                end
            end
            S_LIST: begin
                if (w_out_free) begin
                    // head goes out, the occupied part of the chain rotates by one
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (CMP_W'(i) + CMP_W'(1) < w_cnt_x) o_ctl.cmd[i] = CELL_RIGHT;
                        else if (CMP_W'(i) + CMP_W'(1) == w_cnt_x) o_ctl.cmd[i] = CELL_WRAP;
                    end
                    n_out_valid       = 1'b1;
                    n_out.item_value  = i_head;
                    n_out.status      = ST_OK;
                    n_out.entry_count = ECNT_W'(r_count);
                    n_out.last_item   = w_list_last;
                    n_list_idx        = r_list_idx + LIDX_W'(1);
                    if (w_list_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_list_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_list_idx  <= n_list_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above capacity");

    a_list_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_count != '0 && CMP_W'(r_list_idx) < w_cnt_x))
        else $error("listing walks past the stored entries");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.operation != OP_LIST_ALL)
            |=> (r_out_valid && r_out.last_item && r_state == S_IDLE))
        else $error("update request did not give one final result");

    a_count_stable_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |=> $stable(r_count))
        else $error("count moved while listing");

endmodule

[tb/ple_list_checker.sv]
`timescale 1ns / 1ps
// list mirror and beat-by-beat checker for the positional list engine
module ple_list_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ple_pkg::t_in_beat  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ple_pkg::t_out_beat i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import ple_pkg::*;

    logic signed [VAL_W-1:0] mirror_vals [MAX_ENTRIES];
    int                      mirror_count = 0;
    t_out_beat               expected_beats [$];
    int                      mismatches = 0;
    int                      pending_now = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_now;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic queue_result(input logic signed [VAL_W-1:0] val,
                                input logic [ST_W-1:0] st, input logic last);
        t_out_beat b;
        b.item_value  = val;
        b.status      = st;
        b.entry_count = ECNT_W'(mirror_count);
        b.last_item   = last;
        expected_beats.push_back(b);
    endtask

    // put a value at zero-based slot, later entries move back
    function automatic logic [ST_W-1:0] place_at(input int slot,
                                                 input logic signed [VAL_W-1:0] v);
        int i;
        if (mirror_count >= MAX_ENTRIES) return ST_FULL;
        if (slot > mirror_count) return ST_RANGE;
        for (i = mirror_count; i > slot; i--) mirror_vals[i] = mirror_vals[i-1];
        mirror_vals[slot] = v;
        mirror_count++;
        return ST_OK;
    endfunction

    // drop zero-based slot, later entries move forward
    function automatic logic [ST_W-1:0] drop_at(input int slot);
        int i;
        if (mirror_count == 0) return ST_EMPTY;
        if (slot >= mirror_count) return ST_RANGE;
        for (i = slot; i + 1 < mirror_count; i++) mirror_vals[i] = mirror_vals[i+1];
        mirror_count--;
        return ST_OK;
    endfunction

    task automatic predict_request(input t_in_beat req);
        logic [ST_W-1:0] st;
        int              i;
        st = ST_OK;
        case (req.operation)
            OP_APPEND:    st = place_at(mirror_count, req.value);
            OP_PREPEND:   st = place_at(0, req.value);
            OP_REM_LAST:  st = (mirror_count == 0) ? ST_EMPTY : drop_at(mirror_count - 1);
            OP_REM_FIRST: st = drop_at(0);
            OP_INSERT_AT: begin
                if (mirror_count == 0) st = place_at(0, req.value);
                else if (mirror_count >= MAX_ENTRIES) st = ST_FULL;
                else if (req.position == 0) st = ST_RANGE;
                else st = place_at(int'(req.position) - 1, req.value);
            end
            OP_REMOVE_AT: begin
                if (mirror_count == 0) st = ST_EMPTY;
                else if (req.position == 0) st = ST_RANGE;
                else st = drop_at(int'(req.position) - 1);
            end
            default: st = ST_OK;
        endcase
        if (req.operation != OP_LIST_ALL) begin
            queue_result('0, st, 1'b1);
        end else if (mirror_count == 0) begin
            queue_result('0, ST_EMPTY, 1'b1);
        end else begin
            for (i = 0; i < mirror_count; i++)
                queue_result(mirror_vals[i], ST_OK, (i + 1 == mirror_count));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            mirror_count = 0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat value %0d status %0d count %0d last %0b",
                        i_out_data.item_value, i_out_data.status,
                        i_out_data.entry_count, i_out_data.last_item));
                end else begin
                    want = expected_beats.pop_front();
                    if (i_out_data.item_value !== want.item_value ||
                        i_out_data.status !== want.status ||
                        i_out_data.entry_count !== want.entry_count ||
                        i_out_data.last_item !== want.last_item)
                        report_mismatch($sformatf(
                            "got/exp value %0d/%0d status %0d/%0d count %0d/%0d last %0b/%0b",
                            i_out_data.item_value, want.item_value,
                            i_out_data.status, want.status,
                            i_out_data.entry_count, want.entry_count,
                            i_out_data.last_item, want.last_item));
                end
            end
            if (i_in_valid && i_in_ready) predict_request(i_in_data);
        end
        pending_now <= expected_beats.size();
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// stimulus, handshake pacing and verdict for the positional list engine
module testbench;
    import ple_pkg::*;

    // opcode the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

    // random traffic shaping
    localparam int MODE_GROW       = 0;
    localparam int MODE_CHURN      = 1;
    localparam int MODE_SHRINK     = 2;
    localparam int RANDOM_REQUESTS = 80;

    // long receiver hold to back the block up into its input
    localparam int HOLD_CYCLES = 300;

    // worst case is about 150 requests of 16 beats, each beat stalled by the longest receiver pause,
    // plus sender gaps and the hold; the limit is about five times that
    localparam int CYCLE_LIMIT = 800_000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_beat  in_data;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_beat out_data;

    int   fail_count;
    int   pending;
    int   cycle_count = 0;
    int   sink_pause = 0;
    logic calm = 1'b0;
    logic squeeze_go = 1'b0;
    logic sink_frozen = 1'b0;

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    positional_list_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    ple_list_checker list_scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // idle length: mostly a few cycles, now and then a long one
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return $urandom_range(1, 3);
        if (roll < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // random request, op mix chosen to grow, shrink or stir the list
    function automatic t_in_beat pick_request(input int mode);
        t_in_beat req;
        int       roll;
        roll = $urandom_range(0, 99);
        case (mode)
            MODE_GROW:
                req.operation = (roll < 45) ? OP_APPEND :
                                (roll < 70) ? OP_PREPEND :
                                (roll < 95) ? OP_INSERT_AT : OP_LIST_ALL;
            MODE_SHRINK:
                req.operation = (roll < 35) ? OP_REM_LAST :
                                (roll < 60) ? OP_REM_FIRST :
                                (roll < 90) ? OP_REMOVE_AT : OP_LIST_ALL;
            default:
                req.operation = (roll < 4) ? OP_UNUSED : OP_W'($urandom_range(0, 6));
        endcase
        // mostly near the valid range, sometimes every position bit
        if ($urandom_range(0, 4) == 0) req.position = POS_W'($urandom_range(0, 31));
        else req.position = POS_W'($urandom_range(0, 17));
        case ($urandom_range(0, 7))
            0:       req.value = VAL_MIN;
            1:       req.value = VAL_MAX;
            2:       req.value = $urandom_range(0, 15) - 8;
            default: req.value = $urandom();
        endcase
        return req;
    endfunction

    // offer one beat, hold it until taken, then maybe go quiet for a while
    task automatic send_request(input t_in_beat req);
        int pause;
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (!in_ready);
        if (!calm && $urandom_range(0, 2) == 0) begin
            pause = idle_cycles();
            in_valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
    endtask

    // receiver: random stalls between beats, frozen during the hold
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready  <= 1'b0;
            sink_pause <= 0;
        end else if (sink_frozen) begin
            out_ready <= 1'b0;
        end else if (sink_pause != 0) begin
            out_ready  <= 1'b0;
            sink_pause <= sink_pause - 1;
        end else begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) sink_pause <= idle_cycles();
        end
    end

    // one long receiver hold early in the random traffic
    initial begin : receiver_hold
        wait (squeeze_go);
        @(posedge clk);
        sink_frozen <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_frozen <= 1'b0;
    end

    // watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_beat req;
        int       mode;
        int       phase;
        int       requests_done;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // empty list: listing and every removal report empty
        send_request('{OP_LIST_ALL,  5'd0, 32'sd0});
        send_request('{OP_REM_LAST,  5'd0, 32'sd0});
        send_request('{OP_REM_FIRST, 5'd0, 32'sd0});
        send_request('{OP_REMOVE_AT, 5'd5, 32'sd0});
        // insert into an empty list works even at position zero
        send_request('{OP_INSERT_AT, 5'd0, VAL_MIN});
        send_request('{OP_LIST_ALL,  5'd0, 32'sd0});
        // positions out of range for insert and remove
        send_request('{OP_INSERT_AT, 5'd0, 32'sd7});
        send_request('{OP_INSERT_AT, 5'd3, 32'sd7});
        send_request('{OP_REMOVE_AT, 5'd0, 32'sd0});
        send_request('{OP_REMOVE_AT, 5'd2, 32'sd0});
        // build a short list from both ends and the middle
        send_request('{OP_APPEND,    5'd0, VAL_MAX});
        send_request('{OP_PREPEND,   5'd0, 32'sd0});
        send_request('{OP_INSERT_AT, 5'd2, -32'sd1});
        send_request('{OP_LIST_ALL,  5'd0, 32'sd0});
        send_request('{OP_REMOVE_AT, 5'd2, 32'sd0});
        send_request('{OP_REM_FIRST, 5'd0, 32'sd0});
        send_request('{OP_REM_LAST,  5'd0, 32'sd0});
        // one entry left, removing the last one empties the list
        send_request('{OP_REM_LAST,  5'd0, 32'sd0});
        send_request('{OP_LIST_ALL,  5'd0, 32'sd0});
        // unused opcode, top position bits set
        send_request('{OP_UNUSED,    5'd31, -32'sd1});
        send_request('{OP_INSERT_AT, 5'd31, 32'sh5a5a_a5a5});
        send_request('{OP_INSERT_AT, 5'd2,  32'sh0123_4567});

        // random traffic in phases; grow phases run into a full list,
        // shrink phases drain it, churn phases mix everything
        squeeze_go    <= 1'b1;
        phase         = 0;
        requests_done = 0;
        while (requests_done < RANDOM_REQUESTS) begin
            case (phase % 6)
                0, 4:    mode = MODE_GROW;
                2, 5:    mode = MODE_SHRINK;
                default: mode = MODE_CHURN;
            endcase
            // some phases run back to back with no idling at all
            calm <= ($urandom_range(0, 3) == 0);
            repeat ((mode == MODE_CHURN) ? 20 : 24) begin
                req = pick_request(mode);
                send_request(req);
                if (req.operation != OP_UNUSED) requests_done++;
            end
            phase++;
        end
        in_valid <= 1'b0;

        // drain: let the last prediction land, then wait out the results
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
